// ===== rtl/mirror_alpha_blend_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Mirror alpha blend unit: assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MIRROR_ALPHA_BLEND_UNIT_ASSERT_SVH
`define MIRROR_ALPHA_BLEND_UNIT_ASSERT_SVH

`ifndef SYNTH
// condition holds at every clock edge out of reset
`define MAB_ASSERT_ALWAYS(label, clk_sig, rstn_sig, cond) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (cond)) \
		else $error("mab assertion failed");
// antecedent implies consequent in the same cycle
`define MAB_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error("mab assertion failed");
// antecedent implies consequent in the next cycle
`define MAB_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error("mab assertion failed");
`else
`define MAB_ASSERT_ALWAYS(label, clk_sig, rstn_sig, cond)
`define MAB_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons)
`define MAB_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)
`endif

`endif

// ===== rtl/mab_pkg.sv =====
// ----------------------------------------------------------------------------
// Mirror alpha blend package
// Payload types, register indexes and pixel classification codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mab_pkg;

	// one BGRA pixel
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] opacity;
	} pixel_t;

	// one blended result
	typedef struct packed {
		logic [10:0] column;
		logic [7:0]  out_blue;
		logic [7:0]  out_green;
		logic [7:0]  out_red;
		logic [7:0]  out_opacity;
		logic        last_of_run;
	} result_t;

	localparam int CFG_DATA_W = 12;

	// register indexes
	localparam logic REG_ROW_WIDTH    = 1'b0;
	localparam logic REG_BLEND_WEIGHT = 1'b1;

	localparam logic [11:0] ROW_WIDTH_RESET    = 12'd640;
	localparam logic [7:0]  BLEND_WEIGHT_RESET = 8'd255;

	// pixel classes by column position
	localparam logic [1:0] KIND_STORE  = 2'd0;
	localparam logic [1:0] KIND_MIDDLE = 2'd1;
	localparam logic [1:0] KIND_PAIR   = 2'd2;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int FIFO_CW    = 4;

endpackage

`default_nettype wire

// ===== rtl/mirror_alpha_blend_unit.sv =====
// ----------------------------------------------------------------------------
// Mirror alpha blend unit
// Blends each pixel of a BGRA row stream with its horizontal mirror.
// ----------------------------------------------------------------------------
//  channel  signals                      moves
//  in       in_valid/in_ready/in_data    one BGRA pixel per transfer
//  out      out_valid/out_ready/out_data one blended pixel per transfer
//  cfg      cfg_write/cfg_index/cfg_data register write, no wait
//
// First-half pixels give no result; a second-half pixel other than the middle
// one gives two results through the single output port, so in that half the
// input is held back by the output when the 8-entry result queue lacks room.
// A pixel reaches the output through stage 1, stage 2 and the result queue.
// Reset clears control state only; the half-row store and data are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mirror_alpha_blend_unit_assert.svh"

module mirror_alpha_blend_unit #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire mab_pkg::pixel_t                   in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output mab_pkg::result_t                       out_data,
	input  wire logic                              cfg_write,
	input  wire logic                              cfg_index,
	input  wire logic [mab_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int HALF_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W      = (WW > mab_pkg::CFG_DATA_W) ? WW : mab_pkg::CFG_DATA_W;
	localparam int CNT_W      = mab_pkg::FIFO_CW;
	localparam int PTR_W      = mab_pkg::FIFO_AW;
	localparam int RESV_W     = CNT_W + 1;

	// configuration
	logic [11:0] row_width_q;
	logic [7:0]  blend_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= mab_pkg::ROW_WIDTH_RESET;
			blend_weight_q <= mab_pkg::BLEND_WEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mab_pkg::REG_ROW_WIDTH: begin
					row_width_q <= cfg_data[11:0];
				end
				mab_pkg::REG_BLEND_WEIGHT: begin
					blend_weight_q <= cfg_data[7:0];
				end
			endcase
		end
	end

	// column tracking and classification
	logic [CW-1:0]    col_count_q;
	logic [CMP_W-1:0] rw_ext, w_eff, half_w, cnt_ext, c_ext, c_inc, m_ext;
	logic [1:0]       kind_new, n_new;
	logic [ADDR_W-1:0] mem_addr;
	logic             accept;

	always_comb begin
		rw_ext  = CMP_W'(row_width_q);
		if (rw_ext == '0) begin
			w_eff = CMP_W'(1);
		end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = rw_ext;
		end
		half_w  = w_eff >> 1;
		cnt_ext = CMP_W'(col_count_q);
		// restart when the width shrank under the counter
		c_ext   = (cnt_ext >= w_eff) ? '0 : cnt_ext;
		c_inc   = c_ext + CMP_W'(1);
		m_ext   = w_eff - CMP_W'(1) - c_ext;
		if (c_ext < half_w) begin
			kind_new = mab_pkg::KIND_STORE;
			n_new    = 2'd0;
		end else if (w_eff[0] && c_ext == half_w) begin
			kind_new = mab_pkg::KIND_MIDDLE;
			n_new    = 2'd1;
		end else begin
			kind_new = mab_pkg::KIND_PAIR;
			n_new    = 2'd2;
		end
		mem_addr = (kind_new == mab_pkg::KIND_STORE) ? c_ext[ADDR_W-1:0] : m_ext[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
		end else if (accept) begin
			col_count_q <= (c_inc >= w_eff) ? '0 : c_inc[CW-1:0];
		end
	end

	// half-row store
	mab_pkg::pixel_t mem [HALF_DEPTH];
	mab_pkg::pixel_t partner_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			if (kind_new == mab_pkg::KIND_STORE) begin
				mem[mem_addr] <= in_data;
			end else begin
				partner_s1 <= mem[mem_addr];
			end
		end
	end

	// stage 1: input register
	logic             v_s1;
	logic [1:0]       kind_s1;
	mab_pkg::pixel_t  px_s1;
	logic [10:0]      col_self_s1, col_mirr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && (kind_new != mab_pkg::KIND_STORE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind_new;
			px_s1       <= in_data;
			col_self_s1 <= c_ext[10:0];
			col_mirr_s1 <= m_ext[10:0];
		end
	end

	// stage 1 lanes: magnitude of the difference times weight
	logic [3:0][7:0]  px_ch_s1, pt_ch_s1;
	logic [3:0]       ge_c;
	logic [3:0][15:0] prod_c;
	logic [7:0]       mag;

	always_comb begin
		px_ch_s1 = px_s1;
		pt_ch_s1 = partner_s1;
		mag      = '0;
		for (int k = 0; k < 4; k++) begin
			ge_c[k]   = px_ch_s1[k] >= pt_ch_s1[k];
			mag       = ge_c[k] ? (px_ch_s1[k] - pt_ch_s1[k]) : (pt_ch_s1[k] - px_ch_s1[k]);
			prod_c[k] = 16'(mag) * 16'(blend_weight_q);
		end
	end

	// stage 2: product register
	logic             v_s2;
	logic [1:0]       kind_s2;
	logic [3:0][7:0]  px_ch_s2, pt_ch_s2;
	logic [3:0]       ge_s2;
	logic [3:0][15:0] prod_s2;
	logic [10:0]      col_self_s2, col_mirr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			kind_s2     <= kind_s1;
			px_ch_s2    <= px_ch_s1;
			pt_ch_s2    <= pt_ch_s1;
			ge_s2       <= ge_c;
			prod_s2     <= prod_c;
			col_self_s2 <= col_self_s1;
			col_mirr_s2 <= col_mirr_s1;
		end
	end

	// stage 2: divide by 255 as add-and-shift (exact below 65535), then blend
	logic [3:0][7:0] res_a, res_b;
	logic [16:0]     sum_f, y_c, sum_c;
	logic [7:0]      q_f, q_c;

	always_comb begin
		sum_f = '0;
		y_c   = '0;
		sum_c = '0;
		q_f   = '0;
		q_c   = '0;
		for (int k = 0; k < 4; k++) begin
			sum_f = 17'(prod_s2[k]) + 17'(prod_s2[k][15:8]) + 17'd1;
			q_f   = sum_f[15:8];
			y_c   = 17'(prod_s2[k]) + 17'd254;
			sum_c = y_c + 17'(y_c[16:8]) + 17'd1;
			q_c   = sum_c[15:8];
			// mirrored partner: original is the stored pixel
			res_a[k] = ge_s2[k] ? (px_ch_s2[k] - q_c) : (px_ch_s2[k] + q_f);
			// current pixel: original is itself
			res_b[k] = ge_s2[k] ? (pt_ch_s2[k] + q_f) : (pt_ch_s2[k] - q_c);
		end
	end

	mab_pkg::result_t first_res, second_res;

	always_comb begin
		if (kind_s2 == mab_pkg::KIND_MIDDLE) begin
			first_res.column      = col_self_s2;
			first_res.out_blue    = px_ch_s2[3];
			first_res.out_green   = px_ch_s2[2];
			first_res.out_red     = px_ch_s2[1];
			first_res.out_opacity = px_ch_s2[0];
			first_res.last_of_run = 1'b1;
		end else begin
			first_res.column      = col_mirr_s2;
			first_res.out_blue    = res_a[3];
			first_res.out_green   = res_a[2];
			first_res.out_red     = res_a[1];
			first_res.out_opacity = res_a[0];
			first_res.last_of_run = 1'b0;
		end
		second_res.column      = col_self_s2;
		second_res.out_blue    = res_b[3];
		second_res.out_green   = res_b[2];
		second_res.out_red     = res_b[1];
		second_res.out_opacity = res_b[0];
		second_res.last_of_run = 1'b1;
	end

	// result queue: up to two writes, one read per cycle
	mab_pkg::result_t fifo_q [mab_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop, push_two;
	logic [1:0]       n_s1, n_s2, n_push;
	logic [RESV_W-1:0] resv;

	assign pop      = out_valid && out_ready;
	assign push_two = v_s2 && (kind_s2 == mab_pkg::KIND_PAIR);
	assign n_push   = v_s2 ? (push_two ? 2'd2 : 2'd1) : 2'd0;
	assign n_s1     = v_s1 ? ((kind_s1 == mab_pkg::KIND_PAIR) ? 2'd2 : 2'd1) : 2'd0;
	assign n_s2     = n_push;

	// reserve queue room for everything in flight plus the new pixel
	assign resv     = RESV_W'(cnt_q) + RESV_W'(n_s1) + RESV_W'(n_s2) + RESV_W'(n_new);
	assign in_ready = resv <= RESV_W'(mab_pkg::FIFO_DEPTH);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (v_s2) begin
			fifo_q[wr_ptr_q] <= first_res;
			if (push_two) begin
				fifo_q[wr_ptr_q + PTR_W'(1)] <= second_res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	assign out_valid = cnt_q != '0;
	assign out_data  = fifo_q[rd_ptr_q];

	// checks
	`MAB_ASSERT_ALWAYS(a_room_reserved, clk, arst_n, (RESV_W'(cnt_q) + RESV_W'(n_s1) + RESV_W'(n_s2)) <= RESV_W'(mab_pkg::FIFO_DEPTH))
	`MAB_ASSERT_NEXT(a_pair_pushes_two, clk, arst_n, push_two && !pop, cnt_q == $past(cnt_q) + CNT_W'(2))
	`MAB_ASSERT_NEXT(a_store_no_result, clk, arst_n, accept && (kind_new == mab_pkg::KIND_STORE), !v_s1)

endmodule

`default_nettype wire

// ===== tb/mab_blend_checker.sv =====
// ----------------------------------------------------------------------------
// Mirror alpha blend checker
// Watches the config port and both pixel channels and keeps its own copy of
// the row width, the blend weight, the column counter and the half-row store.
// It predicts the results of every pixel transfer and compares each result
// transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mab_blend_checker #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  mab_pkg::pixel_t                in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  mab_pkg::result_t               out_data,
	input  logic                           cfg_write,
	input  logic                           cfg_index,
	input  logic [mab_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fault_count,
	output int                             pending
);

	localparam int HALF_DEPTH = MAX_WIDTH / 2;

	logic [11:0]      width_reg;
	logic [7:0]       weight_reg;
	int unsigned      col_count;
	mab_pkg::pixel_t  half_row [0:HALF_DEPTH-1];
	mab_pkg::result_t awaited_pixels [$];
	int               faults;

	function automatic logic [7:0] blend_channel(input logic [7:0] orig, input logic [7:0] mirr);
		int o;
		int mi;
		int w;
		o  = orig;
		mi = mirr;
		w  = weight_reg;
		// floor of the signed difference: round the magnitude up when it is negative
		if (o >= mi)
			return 8'(mi + ((o - mi) * w) / 255);
		return 8'(mi - (((mi - o) * w + 254) / 255));
	endfunction

	function automatic mab_pkg::result_t blended_pixel(input int unsigned col,
		input mab_pkg::pixel_t orig, input mab_pkg::pixel_t mirr, input logic last);
		mab_pkg::result_t r;
		r.column      = col[10:0];
		r.out_blue    = blend_channel(orig.blue, mirr.blue);
		r.out_green   = blend_channel(orig.green, mirr.green);
		r.out_red     = blend_channel(orig.red, mirr.red);
		r.out_opacity = blend_channel(orig.opacity, mirr.opacity);
		r.last_of_run = last;
		return r;
	endfunction

	function automatic bit field_ok(input string name, input logic [10:0] want,
		input logic [10:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic predict_pixel(input mab_pkg::pixel_t px);
		int unsigned     eff;
		int unsigned     c;
		int unsigned     m;
		mab_pkg::pixel_t stored;
		if (width_reg == 0)
			eff = 1;
		else if (width_reg > MAX_WIDTH)
			eff = MAX_WIDTH;
		else
			eff = width_reg;
		// restart the row when the width shrank below the counter
		if (col_count >= eff)
			col_count = 0;
		c = col_count;
		if (c < eff / 2) begin
			half_row[c % HALF_DEPTH] = px;
		end else if (eff[0] && c == eff / 2) begin
			awaited_pixels.push_back(blended_pixel(c, px, px, 1'b1));
		end else begin
			m = eff - 1 - c;
			stored = half_row[m % HALF_DEPTH];
			awaited_pixels.push_back(blended_pixel(m, stored, px, 1'b0));
			awaited_pixels.push_back(blended_pixel(c, px, stored, 1'b1));
		end
		col_count = c + 1;
		if (col_count >= eff)
			col_count = 0;
	endtask

	task automatic compare_result(input mab_pkg::result_t got);
		mab_pkg::result_t want;
		if (awaited_pixels.size() == 0) begin
			$error("result transfer with nothing expected: column %0d", got.column);
			faults++;
		end else begin
			want = awaited_pixels.pop_front();
			faults += !field_ok("column", want.column, got.column);
			faults += !field_ok("out_blue", want.out_blue, got.out_blue);
			faults += !field_ok("out_green", want.out_green, got.out_green);
			faults += !field_ok("out_red", want.out_red, got.out_red);
			faults += !field_ok("out_opacity", want.out_opacity, got.out_opacity);
			faults += !field_ok("last_of_run", want.last_of_run, got.last_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = mab_pkg::ROW_WIDTH_RESET;
			weight_reg = mab_pkg::BLEND_WEIGHT_RESET;
			col_count  = 0;
			faults     = 0;
			awaited_pixels.delete();
			fault_count <= 0;
			pending     <= 0;
		end else begin
			// retire results before adding new ones, so an early result is caught
			if (out_valid && out_ready)
				compare_result(out_data);
			if (in_valid && in_ready)
				predict_pixel(in_data);
			// a register write takes effect for the pixels after this edge
			if (cfg_write) begin
				if (cfg_index == mab_pkg::REG_ROW_WIDTH)
					width_reg = cfg_data[11:0];
				else
					weight_reg = cfg_data[7:0];
			end
			fault_count <= faults;
			pending     <= awaited_pixels.size();
		end
	end

endmodule

// ===== tb/tb_mirror_alpha_blend_unit.sv =====
// ----------------------------------------------------------------------------
// Mirror alpha blend unit testbench
// Drives pixel rows through the blend unit under random idling on both sides,
// with a directed opening, a wide saturated row, rows cut short by a width
// change and one long output hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_mirror_alpha_blend_unit;

	localparam int MAX_WIDTH     = 2048;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int RANDOM_ITEMS  = 1850;
	localparam int WIDE_FEED     = 1030;
	localparam int PRESSURE_PASS = 3;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	mab_pkg::pixel_t                in_data   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	mab_pkg::result_t               out_data;
	logic                           cfg_write = 1'b0;
	logic                           cfg_index = mab_pkg::REG_ROW_WIDTH;
	logic [mab_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	int mismatches;
	int pending;
	bit tx_steady;
	bit rx_steady;
	bit hold_request;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	mirror_alpha_blend_unit #(
		.MAX_WIDTH(MAX_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mab_blend_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fault_count(mismatches),
		.pending(pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pixel(input mab_pkg::pixel_t px);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_pixel(mab_pkg::pixel_t'($urandom));
	endtask

	// keep the enable high across back-to-back writes; the caller drops it
	task automatic write_reg(input logic idx, input logic [mab_pkg::CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [11:0] row_w, input logic [7:0] wt);
		logic [3:0] junk;
		junk = 4'($urandom);
		if ($urandom_range(0, 1)) begin
			write_reg(mab_pkg::REG_ROW_WIDTH, row_w);
			write_reg(mab_pkg::REG_BLEND_WEIGHT, {junk, wt});
		end else begin
			write_reg(mab_pkg::REG_BLEND_WEIGHT, {junk, wt});
			write_reg(mab_pkg::REG_ROW_WIDTH, row_w);
		end
		cfg_write <= 1'b0;
	endtask

	// wait out all expected results, then the pipeline tail of pixels with no result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			stall = rx_steady ? 0 : idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		#24_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int          fed;
		int          pass_no;
		int          n;
		int          r;
		int          eff;
		logic [11:0] w;
		logic [7:0]  wt;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero width acts as one: every pixel is a middle pixel, returned unchanged
		set_mode(12'd0, 8'd0);
		send_pixel('0);
		send_pixel('1);
		send_random(1);
		drain();

		// full weight keeps the original, zero weight takes the mirror
		set_mode(12'd2, 8'd255);
		send_pixel('0);
		send_pixel('1);
		drain();
		set_mode(12'd2, 8'd0);
		send_pixel('1);
		send_pixel('0);
		drain();

		// odd width with a middle pixel, channels pulling both ways
		set_mode(12'd3, 8'd100);
		send_pixel(mab_pkg::pixel_t'{8'hFF, 8'h00, 8'hFF, 8'h00});
		send_random(1);
		send_pixel(mab_pkg::pixel_t'{8'h00, 8'hFF, 8'h00, 8'hFF});
		drain();

		set_mode(12'd5, 8'd1);
		send_pixel(mab_pkg::pixel_t'{8'h00, 8'hFF, 8'h00, 8'hFF});
		send_pixel('1);
		send_random(2);
		send_pixel(mab_pkg::pixel_t'{8'hFF, 8'h00, 8'hFF, 8'h00});
		drain();

		// shrink the width below the counter mid-row: the row restarts
		set_mode(12'd10, 8'd200);
		send_random(7);
		drain();
		set_mode(12'd4, 8'd37);
		send_random(4);
		drain();

		fed = 0;
		pass_no = 0;
		while (fed < RANDOM_ITEMS) begin
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 10)
				wt = 8'd0;
			else if (r < 20)
				wt = 8'd255;
			else
				wt = 8'($urandom);
			if (pass_no == 0) begin
				// saturated width; past the half so the whole store gets written
				set_mode(12'hFFF, wt);
				n = WIDE_FEED;
			end else if (pass_no == PRESSURE_PASS) begin
				set_mode(12'd16, wt);
				n = 160;
				tx_steady = 1'b1;
				rx_steady = 1'b1;
				hold_request = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5)
					w = 12'd0;
				else if (r < 85)
					w = 12'($urandom_range(1, 24));
				else
					w = 12'($urandom_range(25, 200));
				eff = (w == 0) ? 1 : int'(w);
				n = eff * $urandom_range(1, (eff > 24) ? 1 : 4);
				// sometimes stop mid-row so the next width change lands inside a row
				if ($urandom_range(0, 3) == 0)
					n += $urandom_range(1, eff);
				set_mode(w, wt);
			end
			send_random(n);
			fed += n;
			drain();
			pass_no++;
		end

		if (mismatches == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
